### hdl/whpa_pkg.sv
// Shared constants, types and codes for the weighted half-perimeter wirelength block.
package whpa_pkg;

  localparam int DEF_CELL_SLOTS = 1024;
  localparam int DEF_COORD_BITS = 24;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 10;
  localparam int COST_W  = 16;
  localparam int CP_W    = 11;
  localparam int AVG_W   = 34;
  localparam int DSUM_W  = 64;
  localparam int WSUM_W  = 32;

  // The quotient carries 7 extra bits of scaling on top of the doubled distances.
  localparam int AVG_SCALE_SH = 7;
  localparam int SAT_SH       = AVG_W - AVG_SCALE_SH;
  localparam int DIV_STEPS    = AVG_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_PIN    = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  typedef enum logic [2:0] {
    S_RUN,
    S_DRAIN,
    S_START,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic capture;
    logic div_step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_full;
  } dp_status_t;

endpackage

### hdl/whpa_if.sv
// Request and result channel interfaces for the wirelength block.
interface whpa_in_if #(
  parameter int COORD_BITS = whpa_pkg::DEF_COORD_BITS
);
  import whpa_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [IDX_W-1:0]        cell_index;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-2:0]   size_w;
  logic [COORD_BITS-2:0]   size_h;
  logic [COST_W-1:0]       net_cost;
  logic                    pin_last;

  modport source (
    output valid, op, cell_index, pos_x, pos_y, size_w, size_h, net_cost, pin_last,
    input  ready
  );
  modport sink (
    input  valid, op, cell_index, pos_x, pos_y, size_w, size_h, net_cost, pin_last,
    output ready
  );
endinterface

interface whpa_out_if;
  import whpa_pkg::*;

  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] average_wirelength;

  modport source (
    output valid, average_wirelength,
    input  ready
  );
  modport sink (
    input  valid, average_wirelength,
    output ready
  );
endinterface

### hdl/whpa_ctrl.sv
// Controller: request acceptance, pipeline drain and divider sequencing for finish.
module whpa_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [whpa_pkg::OP_W-1:0] in_op,
  input  logic                   out_ready,
  input  whpa_pkg::dp_status_t   status,
  output logic                   in_ready,
  output whpa_pkg::ctrl_cmd_t    cmd
);
  import whpa_pkg::*;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      S_RUN: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && (in_op == OP_FINISH)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // Every pin ahead of the finish must have reached the sums.
        if (!status.pipe_busy) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.capture = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!status.out_full || out_ready) begin
          cmd.emit  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      default: begin
        state_nxt = S_RUN;
      end
    endcase
  end

  a_capture_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> !status.pipe_busy)
    else $error("finish captured the sums while pins were still in flight");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!status.out_full || out_ready))
    else $error("result overwritten before it was taken");

  a_capture_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (cmd.div_step && !in_ready))
    else $error("divider did not start after capture");

endmodule

### hdl/whpa_dp.sv
// Datapath: cell table, bounding-box pipeline, weighted sums and radix-2 divider.
module whpa_dp #(
  parameter int CELL_SLOTS = whpa_pkg::DEF_CELL_SLOTS,
  parameter int COORD_BITS = whpa_pkg::DEF_COORD_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  whpa_pkg::ctrl_cmd_t           cmd,
  output whpa_pkg::dp_status_t          status,
  input  logic [whpa_pkg::OP_W-1:0]     in_op,
  input  logic [whpa_pkg::IDX_W-1:0]    in_cell_index,
  input  logic signed [COORD_BITS-1:0]  in_pos_x,
  input  logic signed [COORD_BITS-1:0]  in_pos_y,
  input  logic [COORD_BITS-2:0]         in_size_w,
  input  logic [COORD_BITS-2:0]         in_size_h,
  input  logic [whpa_pkg::COST_W-1:0]   in_net_cost,
  input  logic                          in_pin_last,
  input  logic                          cfg_valid,
  input  logic [whpa_pkg::CP_W-1:0]     cfg_data,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [whpa_pkg::AVG_W-1:0]    out_avg
);
  import whpa_pkg::*;

  localparam int AW   = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
  localparam int SW   = COORD_BITS - 1;
  localparam int MW   = 2 * COORD_BITS + 2 * SW;
  localparam int BW   = COORD_BITS + 2;
  localparam int DW   = COORD_BITS + 3;
  localparam int TW   = DW + COST_W;

  localparam logic signed [BW-1:0] BOX_POS_MAX = {1'b0, {(BW-1){1'b1}}};
  localparam logic signed [BW-1:0] BOX_NEG_MIN = {1'b1, {(BW-1){1'b0}}};

  // Cell table and configuration.
  logic [MW-1:0]   mem [CELL_SLOTS];
  logic [MW-1:0]   rd_r;
  logic [CP_W-1:0] cells_placed_r;

  logic            in_table;
  logic            pin_ok;
  logic [AW-1:0]   addr;

  // Stage 1: row read; stage 2: box update; stage 3: half-perimeter; stage 4: product.
  logic               p1_act_r, p1_ok_r, p1_last_r;
  logic [COST_W-1:0]  p1_cost_r;
  logic signed [BW-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic               has_pin_r;
  logic               p2_vld_r;
  logic [COST_W-1:0]  p2_cost_r;
  logic signed [BW-1:0] c_min_x_r, c_max_x_r, c_min_y_r, c_max_y_r;
  logic               p3_vld_r;
  logic [COST_W-1:0]  p3_cost_r;
  logic [DW-1:0]      d2_r;
  logic               p4_vld_r;
  logic [COST_W-1:0]  p4_cost_r;
  logic [TW-1:0]      term_r;

  logic [DSUM_W-1:0]  dsum_r;
  logic [WSUM_W-1:0]  wsum_r;

  // Divider and result.
  logic [WSUM_W-1:0]  div_w_r;
  logic [WSUM_W-1:0]  rem_r;
  logic [AVG_W-1:0]   qsh_r;
  logic               zero_r, sat_r;
  logic               out_valid_r;
  logic [AVG_W-1:0]   out_avg_r;

  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic [SW-1:0]        rd_w, rd_h;
  logic signed [BW-1:0] cx, cy;
  logic signed [BW-1:0] n_min_x, n_max_x, n_min_y, n_max_y;
  logic                 n_has;
  logic signed [DW-1:0] dx, dy;
  logic [DSUM_W:0]      dsum_add;
  logic [WSUM_W:0]      wsum_add;
  logic [WSUM_W:0]      div_trial;
  logic [WSUM_W:0]      div_diff;

  assign in_table = (int'(in_cell_index) < CELL_SLOTS);
  assign pin_ok   = in_table && ({1'b0, in_cell_index} < cells_placed_r);
  assign addr     = AW'(in_cell_index);

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_op == OP_LOAD) && in_table) begin
      mem[addr] <= {in_pos_x, in_pos_y, in_size_w, in_size_h};
    end
    if (cmd.accept && (in_op == OP_PIN)) begin
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_placed_r <= '0;
    end else if (cfg_valid) begin
      cells_placed_r <= cfg_data;
    end
  end

  // Doubled centres keep the half-widths exact.
  assign rd_x = rd_r[MW-1 -: COORD_BITS];
  assign rd_y = rd_r[MW-COORD_BITS-1 -: COORD_BITS];
  assign rd_w = rd_r[2*SW-1 -: SW];
  assign rd_h = rd_r[SW-1:0];
  assign cx   = {rd_x[COORD_BITS-1], rd_x, 1'b0} + {3'b000, rd_w};
  assign cy   = {rd_y[COORD_BITS-1], rd_y, 1'b0} + {3'b000, rd_h};

  always_comb begin
    n_min_x = min_x_r;
    n_max_x = max_x_r;
    n_min_y = min_y_r;
    n_max_y = max_y_r;
    n_has   = has_pin_r;
    if (p1_ok_r) begin
      if (cx < min_x_r) n_min_x = cx;
      if (cx > max_x_r) n_max_x = cx;
      if (cy < min_y_r) n_min_y = cy;
      if (cy > max_y_r) n_max_y = cy;
      n_has = 1'b1;
    end
  end

  assign dx = {c_max_x_r[BW-1], c_max_x_r} - {c_min_x_r[BW-1], c_min_x_r};
  assign dy = {c_max_y_r[BW-1], c_max_y_r} - {c_min_y_r[BW-1], c_min_y_r};

  assign dsum_add = {1'b0, dsum_r} + (DSUM_W+1)'(term_r);
  assign wsum_add = {1'b0, wsum_r} + (WSUM_W+1)'(p4_cost_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_act_r  <= 1'b0;
      p1_ok_r   <= 1'b0;
      p2_vld_r  <= 1'b0;
      p3_vld_r  <= 1'b0;
      p4_vld_r  <= 1'b0;
      has_pin_r <= 1'b0;
      min_x_r   <= BOX_POS_MAX;
      min_y_r   <= BOX_POS_MAX;
      max_x_r   <= BOX_NEG_MIN;
      max_y_r   <= BOX_NEG_MIN;
      dsum_r    <= '0;
      wsum_r    <= '0;
    end else begin
      p1_act_r <= cmd.accept && (in_op == OP_PIN);
      p1_ok_r  <= cmd.accept && (in_op == OP_PIN) && pin_ok;

      // A closing pin hands the box on and starts the next net empty.
      p2_vld_r <= p1_act_r && p1_last_r && n_has;
      if (cmd.capture || (p1_act_r && p1_last_r)) begin
        has_pin_r <= 1'b0;
        min_x_r   <= BOX_POS_MAX;
        min_y_r   <= BOX_POS_MAX;
        max_x_r   <= BOX_NEG_MIN;
        max_y_r   <= BOX_NEG_MIN;
      end else if (p1_act_r) begin
        has_pin_r <= n_has;
        min_x_r   <= n_min_x;
        min_y_r   <= n_min_y;
        max_x_r   <= n_max_x;
        max_y_r   <= n_max_y;
      end

      p3_vld_r <= p2_vld_r;
      p4_vld_r <= p3_vld_r;

      if (cmd.capture) begin
        dsum_r <= '0;
        wsum_r <= '0;
      end else if (p4_vld_r) begin
        dsum_r <= dsum_add[DSUM_W] ? '1 : dsum_add[DSUM_W-1:0];
        wsum_r <= wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p1_last_r <= in_pin_last;
      p1_cost_r <= in_net_cost;
    end
    if (p1_act_r) begin
      p2_cost_r <= p1_cost_r;
      c_min_x_r <= n_min_x;
      c_max_x_r <= n_max_x;
      c_min_y_r <= n_min_y;
      c_max_y_r <= n_max_y;
    end
    if (p2_vld_r) begin
      p3_cost_r <= p2_cost_r;
      d2_r      <= DW'(dx) + DW'(dy);
    end
    if (p3_vld_r) begin
      p4_cost_r <= p3_cost_r;
      term_r    <= TW'(p3_cost_r) * TW'(d2_r);
    end
  end

  // Restoring division of (sum << 7) by the weight, one quotient bit a cycle.
  // The partial remainder starts from sum >> 27, which is below the weight
  // whenever the quotient does not saturate.
  assign div_trial = {rem_r, qsh_r[AVG_W-1]};
  assign div_diff  = div_trial - {1'b0, div_w_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      div_w_r <= wsum_r;
      rem_r   <= dsum_r[SAT_SH+WSUM_W-1:SAT_SH];
      qsh_r   <= {dsum_r[SAT_SH-1:0], {AVG_SCALE_SH{1'b0}}};
      zero_r  <= (wsum_r == '0) || (cells_placed_r <= CP_W'(1));
      sat_r   <= dsum_r >= {{(DSUM_W-WSUM_W-SAT_SH){1'b0}}, wsum_r, {SAT_SH{1'b0}}};
    end else if (cmd.div_step) begin
      if (!div_diff[WSUM_W]) begin
        rem_r <= div_diff[WSUM_W-1:0];
        qsh_r <= {qsh_r[AVG_W-2:0], 1'b1};
      end else begin
        rem_r <= div_trial[WSUM_W-1:0];
        qsh_r <= {qsh_r[AVG_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_avg_r <= zero_r ? '0 : (sat_r ? '1 : qsh_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_avg          = out_avg_r;
  assign status.pipe_busy = p1_act_r || p2_vld_r || p3_vld_r || p4_vld_r;
  assign status.out_full  = out_valid_r;

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    has_pin_r |-> ((max_x_r >= min_x_r) && (max_y_r >= min_y_r)))
    else $error("open net box has crossed bounds");

  a_dist_needs_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (wsum_r == '0) |-> (dsum_r == '0))
    else $error("distance accumulated without any weight");

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> ((dsum_r == '0) && (wsum_r == '0) && !has_pin_r))
    else $error("finish did not clear the sums and the open net");

endmodule

### hdl/weighted_hpwl_average.sv
// Top level of the weighted mean half-perimeter wirelength block.
//
//  channel   direction  handshake            payload
//  in_chan   in         valid / ready        op, cell_index, pos_x, pos_y, size_w,
//                                            size_h, net_cost, pin_last
//  out_chan  out        valid / ready        average_wirelength (Q26.8)
//  cfg       in         cfg_valid/cfg_ready  cfg_cells_placed
//
// Load and pin requests are taken one per cycle; a pin reaches the sums through
// the registered table read, box, distance and product stages.
// A finish request drains that pipeline, captures the sums, runs the
// one-bit-a-cycle divider and then loads the result.
// Reset is synchronous; the cell table is not cleared and must be loaded before use.
// Requests stall only during a finish and while its result waits for the output.
module weighted_hpwl_average #(
  parameter int CELL_SLOTS = whpa_pkg::DEF_CELL_SLOTS,
  parameter int COORD_BITS = whpa_pkg::DEF_COORD_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  whpa_in_if.sink                        in_chan,
  whpa_out_if.source                     out_chan,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [whpa_pkg::CP_W-1:0]      cfg_cells_placed
);
  import whpa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  whpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_op     (in_chan.op),
    .out_ready (out_chan.ready),
    .status    (status),
    .in_ready  (in_chan.ready),
    .cmd       (cmd)
  );

  whpa_dp #(
    .CELL_SLOTS (CELL_SLOTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_op         (in_chan.op),
    .in_cell_index (in_chan.cell_index),
    .in_pos_x      (in_chan.pos_x),
    .in_pos_y      (in_chan.pos_y),
    .in_size_w     (in_chan.size_w),
    .in_size_h     (in_chan.size_h),
    .in_net_cost   (in_chan.net_cost),
    .in_pin_last   (in_chan.pin_last),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_cells_placed),
    .out_ready     (out_chan.ready),
    .out_valid     (out_chan.valid),
    .out_avg       (out_chan.average_wirelength)
  );

endmodule
